>>> rtl/core/lla_pkg.sv
// Shared types, request codes and sizes for the log-likelihood accumulator.
package lla_pkg;

  localparam int NUM_WORDS        = 4096;
  localparam int WORD_SLOTS       = 4096;
  localparam int ENTRIES_PER_WORD = 8;

  localparam int REQ_W    = 2;
  localparam int WORD_W   = $clog2(WORD_SLOTS);
  localparam int SEL_W    = $clog2(ENTRIES_PER_WORD);
  localparam int VALUE_W  = 32;
  localparam int SUM_W    = 48;
  localparam int IMAGE_W  = 16;
  localparam int TABLE_AW = WORD_W + SEL_W;
  localparam int EXT_W    = SUM_W + 1 - VALUE_W;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = QPTR_W + 1;

  localparam logic [REQ_W-1:0] REQ_TABLE  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_PARENT = 2'd1;
  localparam logic [REQ_W-1:0] REQ_QUERY  = 2'd2;
  localparam logic [REQ_W-1:0] REQ_TEST   = 2'd3;

  typedef struct packed {
    logic [REQ_W-1:0]          req;
    logic [WORD_W-1:0]         word;
    logic [SEL_W-1:0]          sel;
    logic signed [VALUE_W-1:0] value;
    logic [WORD_W-1:0]         parent;
    logic                      bit_val;
    logic                      last;
    logic                      ok;
  } item_t;

endpackage

>>> rtl/core/lla_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lla_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/core/lla_front.sv
// Front end: accepts input transactions, classifies them and queues them for the back end.
module lla_front
  import lla_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [REQ_W-1:0]          req_type,
  input  logic [WORD_W-1:0]         word_index,
  input  logic [SEL_W-1:0]          entry_sel,
  input  logic signed [VALUE_W-1:0] table_value,
  input  logic [WORD_W-1:0]         parent_word,
  input  logic                      word_bit,
  input  logic                      last_word,
  output logic                      q_valid,
  input  logic                      q_ready,
  output item_t                     q_item
);

  item_t             entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              push;
  logic              pop;
  item_t             new_item;

  assign in_ready = (count != QCNT_W'(QUEUE_DEPTH));
  assign q_valid  = (count != '0);
  assign q_item   = entries[rd_ptr];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_comb begin
    new_item.req     = req_type;
    new_item.word    = word_index;
    new_item.sel     = entry_sel;
    new_item.value   = table_value;
    new_item.parent  = parent_word;
    new_item.bit_val = word_bit;
    new_item.last    = last_word && (req_type == REQ_TEST);
    new_item.ok      = (32'(word_index) < NUM_WORDS);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= new_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> rtl/core/lla_back.sv
// Back end: store access pipeline, saturating accumulator and result register.
module lla_back
  import lla_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      q_valid,
  output logic                      q_ready,
  input  item_t                     q_item,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [IMAGE_W-1:0]        image_index,
  output logic signed [SUM_W-1:0]   log_likelihood
);

  logic                      adv;
  logic                      s1_v, s2_v, s3_v;
  item_t                     s1, s2, s3;
  logic                      s2_qw;
  logic [WORD_W-1:0]         parent_rdata;
  logic                      qa_rdata;
  logic                      qb_rdata;
  logic [VALUE_W-1:0]        table_rdata;
  logic [SEL_W-1:0]          idx;
  logic                      s0_test, s1_test, s2_test, s3_test;
  logic signed [SUM_W-1:0]   sum_reg;
  logic [IMAGE_W-1:0]        image_count;
  logic signed [SUM_W:0]     sum_wide;
  logic signed [SUM_W-1:0]   sum_sat;
  logic signed [SUM_W-1:0]   sum_new;

  assign adv     = !out_valid || out_ready;
  assign q_ready = adv;

  assign s0_test = q_valid && (q_item.req == REQ_TEST);
  assign s1_test = s1_v && (s1.req == REQ_TEST);
  assign s2_test = s2_v && (s2.req == REQ_TEST);
  assign s3_test = s3_v && (s3.req == REQ_TEST);

  lla_ram #(.WIDTH(WORD_W), .DEPTH(WORD_SLOTS)) u_parent_ram (
    .clk   (clk),
    .we    (adv && q_valid && (q_item.req == REQ_PARENT) && q_item.ok),
    .waddr (q_item.word),
    .wdata (q_item.parent),
    .re    (adv && s0_test),
    .raddr (q_item.word),
    .rdata (parent_rdata)
  );

  lla_ram #(.WIDTH(1), .DEPTH(WORD_SLOTS)) u_query_word_ram (
    .clk   (clk),
    .we    (adv && q_valid && (q_item.req == REQ_QUERY) && q_item.ok),
    .waddr (q_item.word),
    .wdata (q_item.bit_val),
    .re    (adv && s0_test),
    .raddr (q_item.word),
    .rdata (qa_rdata)
  );

  lla_ram #(.WIDTH(1), .DEPTH(WORD_SLOTS)) u_query_parent_ram (
    .clk   (clk),
    .we    (adv && s1_v && (s1.req == REQ_QUERY) && s1.ok),
    .waddr (s1.word),
    .wdata (s1.bit_val),
    .re    (adv && s1_test),
    .raddr (parent_rdata),
    .rdata (qb_rdata)
  );

  assign idx = {s2.bit_val, s2_qw, qb_rdata};

  lla_ram #(.WIDTH(VALUE_W), .DEPTH(WORD_SLOTS * ENTRIES_PER_WORD)) u_table_ram (
    .clk   (clk),
    .we    (adv && s2_v && (s2.req == REQ_TABLE) && s2.ok),
    .waddr ({s2.word, s2.sel}),
    .wdata (s2.value),
    .re    (adv && s2_test),
    .raddr ({s2.word, idx}),
    .rdata (table_rdata)
  );

  always_comb begin
    sum_wide = {sum_reg[SUM_W-1], sum_reg} + {{EXT_W{table_rdata[VALUE_W-1]}}, table_rdata};
    if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
      sum_sat = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      sum_sat = sum_wide[SUM_W-1:0];
    end
    sum_new = (s3_test && s3.ok) ? sum_sat : sum_reg;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1    <= q_item;
      s2    <= s1;
      s2_qw <= qa_rdata;
      s3    <= s2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s3_test && s3.last) begin
      image_index    <= image_count;
      log_likelihood <= sum_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v        <= 1'b0;
      s2_v        <= 1'b0;
      s3_v        <= 1'b0;
      out_valid   <= 1'b0;
      sum_reg     <= '0;
      image_count <= '0;
    end else if (adv) begin
      s1_v      <= q_valid;
      s2_v      <= s1_v;
      s3_v      <= s2_v;
      out_valid <= s3_test && s3.last;
      if (s3_test && s3.last) begin
        sum_reg     <= '0;
        image_count <= image_count + 1'b1;
      end else begin
        sum_reg <= sum_new;
      end
    end
  end

endmodule

>>> rtl/core/lut_log_likelihood_accumulator_top.sv
// Top level of the lookup-table log-likelihood accumulator.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+------------------------------------------
//   in      | input     | in_valid / in_ready   | req_type, word_index, entry_sel,
//           |           |                      | table_value, parent_word, word_bit, last_word
//   out     | output    | out_valid / out_ready | image_index, log_likelihood
//
// One transaction is accepted per cycle while the queue has room; the closing test
// transaction passes the queue, the parent, query-bit and table reads, then the add stage.
// The rate is set by the single accumulator add that closes the loop in the last stage.
// Reset clears the queue, the pipeline valid bits, the sum and the image counter;
// the stores hold no reset state. A stalled result freezes the back end while the
// four-entry queue keeps taking transactions until it fills.
module lut_log_likelihood_accumulator_top
  import lla_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [REQ_W-1:0]          req_type,
  input  logic [WORD_W-1:0]         word_index,
  input  logic [SEL_W-1:0]          entry_sel,
  input  logic signed [VALUE_W-1:0] table_value,
  input  logic [WORD_W-1:0]         parent_word,
  input  logic                      word_bit,
  input  logic                      last_word,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [IMAGE_W-1:0]        image_index,
  output logic signed [SUM_W-1:0]   log_likelihood
);

  logic  q_valid;
  logic  q_ready;
  item_t q_item;

  lla_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .req_type    (req_type),
    .word_index  (word_index),
    .entry_sel   (entry_sel),
    .table_value (table_value),
    .parent_word (parent_word),
    .word_bit    (word_bit),
    .last_word   (last_word),
    .q_valid     (q_valid),
    .q_ready     (q_ready),
    .q_item      (q_item)
  );

  lla_back u_back (
    .clk            (clk),
    .rst            (rst),
    .q_valid        (q_valid),
    .q_ready        (q_ready),
    .q_item         (q_item),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .image_index    (image_index),
    .log_likelihood (log_likelihood)
  );

  a_stall_no_pop: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !q_ready)
    else $error("Queue drained while a result was stalled.");

  a_full_has_items: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> q_valid)
    else $error("Input refused while the queue was empty.");

  a_reset_clears_out: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("Result valid right after reset.");

endmodule
